// ===== design/mbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants of the escape-time evaluator
// Fixed-point format, multiplier lane types and configuration register map.
// ----------------------------------------------------------------------------
package mbe_pkg;

	// fixed-point format of coordinates: signed, FRAC_BITS fraction bits
	localparam int FRAC_BITS = 28;

	// shared multiplier lanes
	localparam int MUL_BITS  = 32;
	localparam int PROD_BITS = 2 * MUL_BITS;
	localparam int NUM_LANES = 3;

	typedef logic signed [MUL_BITS-1:0]  mul_op_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;

	// configuration port
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 3;
	localparam int LIMIT_BITS    = 16;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_ORIGIN_REAL = 3'd0;
	localparam cfg_idx_t REG_ORIGIN_IMAG = 3'd1;
	localparam cfg_idx_t REG_STEP_REAL   = 3'd2;
	localparam cfg_idx_t REG_STEP_IMAG   = 3'd3;
	localparam cfg_idx_t REG_ITER_LIMIT  = 3'd4;

	// register reset values
	localparam logic signed [CFG_DATA_BITS-1:0] RST_ORIGIN_REAL = -32'sd671088640;
	localparam logic signed [CFG_DATA_BITS-1:0] RST_ORIGIN_IMAG = 32'sd268435456;
	localparam logic signed [CFG_DATA_BITS-1:0] RST_STEP_REAL   = 32'sd1304894;
	localparam logic signed [CFG_DATA_BITS-1:0] RST_STEP_IMAG   = -32'sd1118481;
	localparam logic [LIMIT_BITS-1:0]           RST_ITER_LIMIT  = 16'd255;

endpackage

// ===== design/mbe_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_in_if: pixel request channel
// Valid/ready channel that carries one pixel coordinate pair.
// ----------------------------------------------------------------------------
interface mbe_in_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] column;
	logic [COORD_BITS-1:0] row;

	modport source (output valid, output column, output row, input ready);
	modport sink   (input valid, input column, input row, output ready);
endinterface

// ===== design/mbe_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_out_if: iteration count channel
// Valid/ready channel that carries one escape-time result.
// ----------------------------------------------------------------------------
interface mbe_out_if #(
	parameter int COUNT_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [COUNT_BITS-1:0] iteration_count;

	modport source (output valid, output iteration_count, input ready);
	modport sink   (input valid, input iteration_count, output ready);
endinterface

// ===== design/mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: escape-time evaluator for one pixel at a time
// Maps a pixel to c = origin + index * step and iterates z = z*z + c.
// ----------------------------------------------------------------------------
// A pixel request is taken only while the evaluator is idle. The pixel is mapped
// to its point in the idle state (index * step in the shared multiplier bank)
// and the point setup state (origin added, z cleared). Each pass of z = z*z + c
// then runs through a multiply state (the shared multiplier bank) and an update
// state (the escape test and the update of z). The iteration limit is tested in
// the multiply state and escape in the update state; the finish state then hands
// the count, at most the iteration limit, to the output register, waiting while
// that register is still full. The output register holds a finished count while
// the next pixel is already being worked on. Coordinates are signed with 28
// fraction bits.
module mandelbrot_escape_time #(
	parameter int COORD_BITS = 12,
	parameter int COUNT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mbe_pkg::CFG_IDX_BITS-1:0]      cfg_idx,
	input  logic [mbe_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	mbe_in_if.sink                                pixel,
	mbe_out_if.source                             result
);

	// point c: origin + index * step; z gains one bit over c
	localparam int C_BITS = mbe_pkg::CFG_DATA_BITS + COORD_BITS + 2;
	localparam int Z_BITS = C_BITS + 1;

	localparam logic signed [Z_BITS-1:0] TWO_Z     =
		Z_BITS'(64'sd2 <<< mbe_pkg::FRAC_BITS);
	localparam logic signed [Z_BITS-1:0] NEG_TWO_Z =
		Z_BITS'(-(64'sd2 <<< mbe_pkg::FRAC_BITS));
	localparam mbe_pkg::prod_t FOUR_P =
		mbe_pkg::prod_t'(64'sd4 <<< mbe_pkg::FRAC_BITS);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CINIT  = 5'b00010,
		ST_MUL    = 5'b00100,
		ST_UPD    = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;

	logic signed [mbe_pkg::CFG_DATA_BITS-1:0] origin_real_q;
	logic signed [mbe_pkg::CFG_DATA_BITS-1:0] origin_imag_q;
	logic signed [mbe_pkg::CFG_DATA_BITS-1:0] step_real_q;
	logic signed [mbe_pkg::CFG_DATA_BITS-1:0] step_imag_q;
	logic [mbe_pkg::LIMIT_BITS-1:0]           limit_q;

	logic signed [C_BITS-1:0] cr_q;
	logic signed [C_BITS-1:0] ci_q;
	logic signed [Z_BITS-1:0] zr_q;
	logic signed [Z_BITS-1:0] zi_q;
	logic [mbe_pkg::LIMIT_BITS-1:0] cnt_q;

	logic                  res_valid_q;
	logic [COUNT_BITS-1:0] res_cnt_q;

	mbe_pkg::mul_op_t op_a    [mbe_pkg::NUM_LANES];
	mbe_pkg::mul_op_t op_b    [mbe_pkg::NUM_LANES];
	mbe_pkg::prod_t   prod_s1 [mbe_pkg::NUM_LANES];

	mbe_pkg::prod_t x2;
	mbe_pkg::prod_t y2;
	mbe_pkg::prod_t mag2;
	logic           big_z;
	logic           escape;
	logic           at_limit;
	logic           slot_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_real_q <= mbe_pkg::RST_ORIGIN_REAL;
			origin_imag_q <= mbe_pkg::RST_ORIGIN_IMAG;
			step_real_q   <= mbe_pkg::RST_STEP_REAL;
			step_imag_q   <= mbe_pkg::RST_STEP_IMAG;
			limit_q       <= mbe_pkg::RST_ITER_LIMIT;
		end else if (cfg_we) begin
			case (cfg_idx)
				mbe_pkg::REG_ORIGIN_REAL: origin_real_q <= cfg_data;
				mbe_pkg::REG_ORIGIN_IMAG: origin_imag_q <= cfg_data;
				mbe_pkg::REG_STEP_REAL:   step_real_q   <= cfg_data;
				mbe_pkg::REG_STEP_IMAG:   step_imag_q   <= cfg_data;
				mbe_pkg::REG_ITER_LIMIT:  limit_q       <= cfg_data[mbe_pkg::LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// steer multiplier operands: pixel mapping while idle, z terms otherwise
	always_comb begin
		case (state_q)
			ST_IDLE: begin
				op_a[0] = step_real_q;
				op_b[0] = mbe_pkg::mul_op_t'(pixel.column);
				op_a[1] = step_imag_q;
				op_b[1] = mbe_pkg::mul_op_t'(pixel.row);
				op_a[2] = '0;
				op_b[2] = '0;
			end
			default: begin
				op_a[0] = mbe_pkg::mul_op_t'(zr_q);
				op_b[0] = mbe_pkg::mul_op_t'(zr_q);
				op_a[1] = mbe_pkg::mul_op_t'(zi_q);
				op_b[1] = mbe_pkg::mul_op_t'(zi_q);
				op_a[2] = mbe_pkg::mul_op_t'(zr_q);
				op_b[2] = mbe_pkg::mul_op_t'(zi_q);
			end
		endcase
	end

	mbe_mul u_mul (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.prod_s1 (prod_s1)
	);

	// escape test: a large component escapes before its square is trusted
	always_comb begin
		x2       = prod_s1[0] >>> mbe_pkg::FRAC_BITS;
		y2       = prod_s1[1] >>> mbe_pkg::FRAC_BITS;
		mag2     = x2 + y2;
		big_z    = (zr_q > TWO_Z) || (zr_q < NEG_TWO_Z) ||
		           (zi_q > TWO_Z) || (zi_q < NEG_TWO_Z);
		escape   = big_z || (mag2 > FOUR_P);
		at_limit = (cnt_q >= limit_q);
		slot_free = !res_valid_q || result.ready;
	end

	// sequencer and pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pixel.valid) begin
						state_q <= ST_CINIT;
					end
				end
				ST_CINIT: begin
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (at_limit) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (escape) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: load a finished count, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && slot_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// point and z datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CINIT: begin
				cr_q <= C_BITS'(origin_real_q) + C_BITS'(prod_s1[0]);
				ci_q <= C_BITS'(origin_imag_q) + C_BITS'(prod_s1[1]);
				zr_q <= '0;
				zi_q <= '0;
			end
			ST_UPD: begin
				if (!escape) begin
					zr_q <= Z_BITS'(x2 - y2) + Z_BITS'(cr_q);
					zi_q <= Z_BITS'(prod_s1[2] >>> (mbe_pkg::FRAC_BITS - 1)) + Z_BITS'(ci_q);
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					res_cnt_q <= COUNT_BITS'(cnt_q);
				end
			end
			default: ;
		endcase
	end

	assign pixel.ready            = (state_q == ST_IDLE);
	assign result.valid           = res_valid_q;
	assign result.iteration_count = res_cnt_q;

	// an accepted pixel always goes straight to point setup
	assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> (state_q == ST_CINIT))
		else $error("pixel accepted without entering point setup");

	// the pass counter never runs past the limit while iterating
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MUL) || (state_q == ST_UPD)) |-> (cnt_q <= limit_q))
		else $error("pass counter beyond iteration limit");

	// an update either finishes or counts exactly one more pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |=>
		((state_q == ST_FINISH) ||
		 (cnt_q == mbe_pkg::LIMIT_BITS'($past(cnt_q) + 1'b1))))
		else $error("pass counter did not advance by one");

	// a finished count waits while the output register is still full
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && res_valid_q && !result.ready) |=>
		(state_q == ST_FINISH))
		else $error("finished count dropped while output was full");

endmodule

// ===== design/mbe_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_mul: shared signed multiplier bank
// Three 32x32 signed lanes with registered products. Used for the pixel to
// point mapping and for the squares and cross product of every iteration.
// ----------------------------------------------------------------------------
module mbe_mul (
	input  logic            clk,
	input  mbe_pkg::mul_op_t op_a    [mbe_pkg::NUM_LANES],
	input  mbe_pkg::mul_op_t op_b    [mbe_pkg::NUM_LANES],
	output mbe_pkg::prod_t   prod_s1 [mbe_pkg::NUM_LANES]
);

	// multiply each lane and register the full product
	always_ff @(posedge clk) begin
		for (int i = 0; i < mbe_pkg::NUM_LANES; i++) begin
			prod_s1[i] <= op_a[i] * op_b[i];
		end
	end

endmodule

// ===== tb/tb_mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time: self-checking bench of the escape-time evaluator
// Walks a directed table of pixels and register writes, then random views.
// Each count is compared with its pinned table value or a fixed-point escape-time predictor.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time;

	localparam int  COORD_BITS   = 12;
	localparam int  COUNT_BITS   = 16;
	localparam int  PLAN_ROWS    = 44;
	localparam int  PHASES       = 8;
	localparam int  PHASE_ITEMS  = 250;
	localparam int  LONG_HOLD    = 700;
	localparam int  TAIL_CYCLES  = 40;
	localparam longint LIMIT_CYCLES = 64'd6_000_000;

	// register indexes that the block must ignore
	localparam mbe_pkg::cfg_idx_t REG_UNUSED_LO = 3'd5;
	localparam mbe_pkg::cfg_idx_t REG_UNUSED_HI = 3'd7;

	localparam longint ESC_TWO  = longint'(2) << mbe_pkg::FRAC_BITS;
	localparam longint ESC_FOUR = longint'(4) << mbe_pkg::FRAC_BITS;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;
	typedef enum logic [1:0] {VIEW_ZOOM, VIEW_DEFAULT, VIEW_FAR, VIEW_RAW} view_kind_t;

	typedef struct packed {
		row_kind_t                         kind;
		mbe_pkg::cfg_idx_t                 idx;
		logic [mbe_pkg::CFG_DATA_BITS-1:0] data;
		coord_t                            column;
		coord_t                            row;
		logic                              pinned;
		count_t                            count;
	} plan_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	mbe_pkg::cfg_idx_t                 cfg_idx;
	logic [mbe_pkg::CFG_DATA_BITS-1:0] cfg_data;

	mbe_in_if  #(.COORD_BITS(COORD_BITS)) pixel_if ();
	mbe_out_if #(.COUNT_BITS(COUNT_BITS)) result_if ();

	mandelbrot_escape_time #(
		.COORD_BITS(COORD_BITS),
		.COUNT_BITS(COUNT_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.pixel   (pixel_if),
		.result  (result_if)
	);

	// shadow copy of the view registers
	logic signed [31:0] view_re0  = mbe_pkg::RST_ORIGIN_REAL;
	logic signed [31:0] view_im0  = mbe_pkg::RST_ORIGIN_IMAG;
	logic signed [31:0] pitch_re  = mbe_pkg::RST_STEP_REAL;
	logic signed [31:0] pitch_im  = mbe_pkg::RST_STEP_IMAG;
	count_t             iter_cap  = mbe_pkg::RST_ITER_LIMIT;

	count_t pending_counts[$];
	int     mismatches   = 0;
	longint cycles       = 0;
	logic   pin_on       = 1'b0;
	count_t pin_count    = '0;
	logic   source_gaps  = 1'b1;
	logic   sink_stalls  = 1'b1;
	logic   long_hold_req = 1'b0;
	int     hold_left    = 0;

	function automatic plan_row_t pix(input int col, input int rw, input logic pinned,
			input int count);
		return '{ROW_PIXEL, mbe_pkg::REG_ORIGIN_REAL, '0, coord_t'(col), coord_t'(rw),
			pinned, count_t'(count)};
	endfunction

	function automatic plan_row_t wr(input mbe_pkg::cfg_idx_t idx, input logic [31:0] data);
		return '{ROW_WRITE, idx, data, '0, '0, 1'b0, '0};
	endfunction

	plan_row_t plan [PLAN_ROWS] = '{
		pix(0, 0, 1, 1), pix(4095, 4095, 1, 1), pix(514, 240, 1, 255),
		wr(REG_UNUSED_LO, 32'h0000_0000), wr(REG_UNUSED_HI, 32'hFFFF_FFFF),
		pix(514, 240, 1, 255),
		wr(mbe_pkg::REG_ITER_LIMIT, 32'hFFFF_0000), pix(514, 240, 1, 0),
		wr(mbe_pkg::REG_ITER_LIMIT, 32'h0000_0001), pix(514, 240, 1, 1),
		wr(mbe_pkg::REG_ITER_LIMIT, 32'h0000_FFFF), pix(514, 240, 1, 65535),
		wr(mbe_pkg::REG_ORIGIN_REAL, 32'h7FFF_FFFF),
		wr(mbe_pkg::REG_ORIGIN_IMAG, 32'h8000_0000),
		wr(mbe_pkg::REG_STEP_REAL, 32'h8000_0000),
		wr(mbe_pkg::REG_STEP_IMAG, 32'h7FFF_FFFF),
		pix(0, 0, 1, 1), pix(4095, 0, 1, 1), pix(0, 4095, 1, 1), pix(4095, 4095, 1, 1),
		pix(2730, 1365, 0, 0),
		wr(mbe_pkg::REG_ORIGIN_REAL, 32'h0), wr(mbe_pkg::REG_ORIGIN_IMAG, 32'h0),
		wr(mbe_pkg::REG_STEP_REAL, 32'h0), wr(mbe_pkg::REG_STEP_IMAG, 32'h0),
		wr(mbe_pkg::REG_ITER_LIMIT, 32'd300), pix(0, 0, 1, 300),
		wr(mbe_pkg::REG_ORIGIN_REAL, 32'hE000_0000), pix(0, 0, 1, 300),
		wr(mbe_pkg::REG_ORIGIN_REAL, 32'h2000_0000), pix(0, 0, 1, 2),
		wr(mbe_pkg::REG_ORIGIN_REAL, 32'h0400_0000), pix(0, 0, 0, 0),
		wr(mbe_pkg::REG_ORIGIN_REAL, 32'h0), wr(mbe_pkg::REG_STEP_REAL, 32'h1),
		wr(mbe_pkg::REG_STEP_IMAG, 32'h1),
		pix(4095, 4095, 0, 0),
		wr(mbe_pkg::REG_ORIGIN_REAL, mbe_pkg::RST_ORIGIN_REAL),
		wr(mbe_pkg::REG_ORIGIN_IMAG, mbe_pkg::RST_ORIGIN_IMAG),
		wr(mbe_pkg::REG_STEP_REAL, mbe_pkg::RST_STEP_REAL),
		wr(mbe_pkg::REG_STEP_IMAG, mbe_pkg::RST_STEP_IMAG),
		wr(mbe_pkg::REG_ITER_LIMIT, 32'(mbe_pkg::RST_ITER_LIMIT)),
		pix(100, 100, 0, 0), pix(700, 479, 0, 0)
	};

	// iterate z = z*z + c from zero with floored products, count the passes
	function automatic count_t escape_count(input coord_t col, input coord_t rw);
		longint cr, ci, zr, zi, mr, mi, x2, y2;
		int unsigned passes;
		cr = longint'(view_re0) + longint'(col) * longint'(pitch_re);
		ci = longint'(view_im0) + longint'(rw) * longint'(pitch_im);
		zr = 0;
		zi = 0;
		passes = 0;
		while (passes < iter_cap) begin
			mr = (zr < 0) ? -zr : zr;
			mi = (zi < 0) ? -zi : zi;
			if (mr > ESC_TWO || mi > ESC_TWO)
				break;
			x2 = (mr * mr) >>> mbe_pkg::FRAC_BITS;
			y2 = (mi * mi) >>> mbe_pkg::FRAC_BITS;
			if (x2 + y2 > ESC_FOUR)
				break;
			zi = ((zr * zi) >>> (mbe_pkg::FRAC_BITS - 1)) + ci;
			zr = x2 - y2 + cr;
			passes++;
		end
		return count_t'(passes);
	endfunction

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("mandelbrot_escape_time test failed");
			$finish;
		end
	end

	// predict each accepted request
	always @(posedge clk) begin
		if (pixel_if.valid && pixel_if.ready)
			pending_counts.push_back(pin_on ? pin_count
				: escape_count(pixel_if.column, pixel_if.row));
	end

	// compare each accepted count with the oldest prediction
	always @(posedge clk) begin
		if (result_if.valid && result_if.ready) begin
			if (pending_counts.size() == 0) begin
				$error("iteration_count: no request pending, got %0d",
					result_if.iteration_count);
				mismatches++;
			end else begin
				if (result_if.iteration_count !== pending_counts[0]) begin
					$error("iteration_count: expected %0d, got %0d",
						pending_counts[0], result_if.iteration_count);
					mismatches++;
				end
				void'(pending_counts.pop_front());
			end
		end
	end

	// receiver: random stall bursts and one long hold-off
	initial begin
		result_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				result_if.ready <= 1'b0;
			end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(0, 10);
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		while (pending_counts.size() != 0)
			@(posedge clk);
	endtask

	// write one register; returns at a falling edge with the enable low
	task automatic write_reg(input mbe_pkg::cfg_idx_t idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			mbe_pkg::REG_ORIGIN_REAL: view_re0 = data;
			mbe_pkg::REG_ORIGIN_IMAG: view_im0 = data;
			mbe_pkg::REG_STEP_REAL:   pitch_re = data;
			mbe_pkg::REG_STEP_IMAG:   pitch_im = data;
			mbe_pkg::REG_ITER_LIMIT:  iter_cap = data[COUNT_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one request after an optional gap; returns at a falling edge
	task automatic offer_pixel(input coord_t col, input coord_t rw);
		if (source_gaps && $urandom_range(0, 3) == 0) begin
			pixel_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		pixel_if.valid  <= 1'b1;
		pixel_if.column <= col;
		pixel_if.row    <= rw;
		@(posedge clk);
		while (!pixel_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stimulus
	initial begin
		coord_t col, rw;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_idx         <= mbe_pkg::REG_ORIGIN_REAL;
		cfg_data        <= '0;
		pixel_if.valid  <= 1'b0;
		pixel_if.column <= '0;
		pixel_if.row    <= '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				pixel_if.valid <= 1'b0;
				wait_drained();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				pin_on    = plan[i].pinned;
				pin_count = plan[i].count;
				offer_pixel(plan[i].column, plan[i].row);
			end
		end
		pin_on = 1'b0;

		// random views; the last phases run without idling
		for (int p = 0; p < PHASES; p++) begin
			pixel_if.valid <= 1'b0;
			wait_drained();
			source_gaps = (p < 6) && (p != 2);
			sink_stalls = (p < 6) && (p != 3);
			case (view_kind_t'(p % 4))
				VIEW_ZOOM: begin
					write_reg(mbe_pkg::REG_ORIGIN_REAL,
						mbe_pkg::RST_ORIGIN_REAL + $urandom_range(0, 32'h2000_0000));
					write_reg(mbe_pkg::REG_ORIGIN_IMAG, $urandom_range(0, 32'h1800_0000));
					write_reg(mbe_pkg::REG_STEP_REAL, $urandom_range(1, 32'h0020_0000));
					write_reg(mbe_pkg::REG_STEP_IMAG,
						32'h0 - $urandom_range(1, 32'h0020_0000));
					write_reg(mbe_pkg::REG_ITER_LIMIT, $urandom_range(1, 300));
				end
				VIEW_DEFAULT: begin
					write_reg(mbe_pkg::REG_ORIGIN_REAL, mbe_pkg::RST_ORIGIN_REAL);
					write_reg(mbe_pkg::REG_ORIGIN_IMAG, mbe_pkg::RST_ORIGIN_IMAG);
					write_reg(mbe_pkg::REG_STEP_REAL, mbe_pkg::RST_STEP_REAL);
					write_reg(mbe_pkg::REG_STEP_IMAG, mbe_pkg::RST_STEP_IMAG);
					case ($urandom_range(0, 2))
						0:       write_reg(mbe_pkg::REG_ITER_LIMIT, 32'd1);
						1:       write_reg(mbe_pkg::REG_ITER_LIMIT, 32'd2);
						default: write_reg(mbe_pkg::REG_ITER_LIMIT, 32'd255);
					endcase
				end
				VIEW_FAR: begin
					// real part stays at or above 3.0, so every pixel escapes after its first pass
					write_reg(mbe_pkg::REG_ORIGIN_REAL,
						$urandom_range(32'h3000_0000, 32'h7FFF_FFFF));
					write_reg(mbe_pkg::REG_ORIGIN_IMAG, $urandom);
					write_reg(mbe_pkg::REG_STEP_REAL, $urandom_range(0, 32'h0010_0000));
					write_reg(mbe_pkg::REG_STEP_IMAG, $urandom);
					write_reg(mbe_pkg::REG_ITER_LIMIT, 32'h0000_FFFF);
				end
				default: begin
					write_reg(mbe_pkg::REG_ORIGIN_REAL, $urandom);
					write_reg(mbe_pkg::REG_ORIGIN_IMAG, $urandom);
					write_reg(mbe_pkg::REG_STEP_REAL, $urandom);
					write_reg(mbe_pkg::REG_STEP_IMAG, $urandom);
					write_reg(mbe_pkg::REG_ITER_LIMIT, $urandom_range(1, 64));
				end
			endcase
			// hold off the receiver once so the block backs up into its input
			if (p == 1)
				long_hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					col = coord_t'($urandom_range(0, 4095));
					rw  = coord_t'($urandom_range(0, 4095));
				end else begin
					col = coord_t'($urandom_range(0, 719));
					rw  = coord_t'($urandom_range(0, 479));
				end
				offer_pixel(col, rw);
			end
		end

		// drain and let any stray count show up
		pixel_if.valid <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("mandelbrot_escape_time test passed");
		else
			$display("mandelbrot_escape_time test failed");
		$finish;
	end

endmodule

// ===== mandelbrot_escape_time.f =====
design/mbe_pkg.sv
design/mbe_in_if.sv
design/mbe_out_if.sv
design/mbe_mul.sv
design/mandelbrot_escape_time.sv
tb/tb_mandelbrot_escape_time.sv
